// ----- hdl/dcrt_pkg.sv -----
// Shared types, widths and status codes for the check request table.
package dcrt_pkg;

   localparam int SLOTS_DEFAULT = 128;

   localparam int IMAGE_W  = 16;
   localparam int BLOCK_W  = 31;
   localparam int STATUS_W = 3;

   localparam logic [STATUS_W-1:0] STATUS_QUEUED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_PENDING = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_TAKEN   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NONE    = 3'd4;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_TAKE    = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [IMAGE_W-1:0] image_id;
      logic [BLOCK_W-1:0] block_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IMAGE_W-1:0]  taken_image;
      logic [BLOCK_W-1:0]  taken_block;
   } rsp_type;

   // scan token passed from cell to cell; slot indexes travel beside it
   typedef struct packed {
      logic               live;
      logic               dup;
      logic               have_free;
      logic               have_valid;
      logic [IMAGE_W-1:0] last_image;
      logic [BLOCK_W-1:0] last_block;
   } tok_type;

   // update broadcast to the cells at the end of a scan
   typedef struct packed {
      logic wr;
      logic clr;
   } cmt_type;

endpackage

// ----- hdl/dcrt_cell.sv -----
// One table slot: holds a pending request and updates the passing scan token.
module dcrt_cell #(
   parameter int SLOTS   = dcrt_pkg::SLOTS_DEFAULT,
   parameter int CELL_ID = 0,
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int LEN_W  = $clog2(SLOTS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  dcrt_pkg::req_type   req,
   input  logic [LEN_W-1:0]    len,
   input  dcrt_pkg::tok_type   prev_tok,
   input  logic [IDX_W-1:0]    prev_free_idx,
   input  logic [IDX_W-1:0]    prev_last_idx,
   output dcrt_pkg::tok_type   out_tok,
   output logic [IDX_W-1:0]    out_free_idx,
   output logic [IDX_W-1:0]    out_last_idx,
   input  dcrt_pkg::cmt_type   cmt,
   input  logic [IDX_W-1:0]    cmt_idx
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);
   localparam logic [LEN_W-1:0] MY_POS = LEN_W'(CELL_ID);

   logic                         valid_ff, valid_in;
   logic [dcrt_pkg::IMAGE_W-1:0] image_ff;
   logic [dcrt_pkg::BLOCK_W-1:0] block_ff;
   dcrt_pkg::tok_type            tok_ff, tok_in;
   logic [IDX_W-1:0]             free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]             last_idx_ff, last_idx_in;
   logic                         active;
   logic                         hit;

   assign active = (MY_POS < len);
   assign hit    = (cmt_idx == MY_IDX);

   always_comb begin
      tok_in      = prev_tok;
      free_idx_in = prev_free_idx;
      last_idx_in = prev_last_idx;
      if (active && valid_ff) begin
         if (image_ff == req.image_id && block_ff == req.block_index) begin
            tok_in.dup = 1'b1;
         end
         tok_in.have_valid = 1'b1;
         tok_in.last_image = image_ff;
         tok_in.last_block = block_ff;
         last_idx_in       = MY_IDX;
      end else if (active && !prev_tok.have_free) begin
         tok_in.have_free = 1'b1;
         free_idx_in      = MY_IDX;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmt.wr && hit) begin
         valid_in = 1'b1;
      end else if (cmt.clr && hit) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      free_idx_ff <= free_idx_in;
      last_idx_ff <= last_idx_in;
      if (cmt.wr && hit) begin
         image_ff <= req.image_id;
         block_ff <= req.block_index;
      end
   end

   assign out_tok      = tok_ff;
   assign out_free_idx = free_idx_ff;
   assign out_last_idx = last_idx_ff;

endmodule

// ----- hdl/dedup_check_request_table.sv -----
// Top level of the deduplicating check request table: controller and cell chain.
//
// Usage notes:
//  - Request channel (req_*): valid/stall. cmd 0 enqueues an (image id, block
//    index) pair, cmd 1 takes the pair in the highest used slot. One request is worked
//    at a time; req_stall is high from acceptance until the result is loaded
//    into the output register.
//  - Response channel (rsp_*): valid/stall, one response per request with a
//    status (queued, already pending, dropped full, taken, nothing pending).
//    Taken image/block fields are zero unless the status is taken.
//  - Each request launches a token down a chain of SLOTS cells, one cell per
//    cycle; every cell checks its own slot against the request and the used
//    length. At the end of the chain the controller decides and broadcasts a
//    single write or clear to the chosen cell.
//  - A request passes the launch register, every cell of the chain, the
//    controller's result register and the output register before rsp_valid;
//    no new request is taken until the previous one has left the controller.
//  - Reset clears all valid bits, the used length and both handshakes at once;
//    slot contents are not cleared and are never seen while invalid.
//  - If rsp_stall holds the previous response, the finished result waits in
//    the controller and no new request is taken until it moves out.
module dedup_check_request_table #(
   parameter int SLOTS  = dcrt_pkg::SLOTS_DEFAULT,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int LEN_W = $clog2(SLOTS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dcrt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dcrt_pkg::rsp_type rsp_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(SLOTS);
   localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);

   logic [1:0]        state_ff, state_in;
   dcrt_pkg::req_type req_ff;
   logic              start_ff;
   logic [LEN_W-1:0]  len_ff, len_in;
   dcrt_pkg::cmt_type cmt_ff, cmt_in;
   logic [IDX_W-1:0]  cmt_idx_ff, cmt_idx_in;
   dcrt_pkg::rsp_type result_ff, result_in;
   logic              rsp_valid_ff, rsp_valid_in;
   dcrt_pkg::rsp_type rsp_data_ff;

   // token chain: entry 0 is the launch point, entry SLOTS leaves the last cell
   dcrt_pkg::tok_type tok_w      [0:SLOTS];
   logic [IDX_W-1:0]  free_idx_w [0:SLOTS];
   logic [IDX_W-1:0]  last_idx_w [0:SLOTS];

   dcrt_pkg::tok_type end_tok;
   logic [IDX_W-1:0]  end_free_idx;
   logic [IDX_W-1:0]  end_last_idx;
   logic [LEN_W-1:0]  taken_next;
   logic              req_take;
   logic              rsp_take;
   logic              rsp_free;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      tok_w[0]      = '0;
      tok_w[0].live = start_ff;
      free_idx_w[0] = '0;
      last_idx_w[0] = '0;
   end

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      dcrt_cell #(
         .SLOTS   (SLOTS),
         .CELL_ID (g)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .req           (req_ff),
         .len           (len_ff),
         .prev_tok      (tok_w[g]),
         .prev_free_idx (free_idx_w[g]),
         .prev_last_idx (last_idx_w[g]),
         .out_tok       (tok_w[g+1]),
         .out_free_idx  (free_idx_w[g+1]),
         .out_last_idx  (last_idx_w[g+1]),
         .cmt           (cmt_ff),
         .cmt_idx       (cmt_idx_ff)
      );
   end

   assign end_tok      = tok_w[SLOTS];
   assign end_free_idx = free_idx_w[SLOTS];
   assign end_last_idx = last_idx_w[SLOTS];
   assign taken_next   = LEN_W'(end_last_idx) + LEN_ONE;

   // Controller: decide once the token leaves the last cell.
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      cmt_in       = '0;
      cmt_idx_in   = cmt_idx_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (end_tok.live) begin
               state_in  = S_DONE;
               result_in = '0;
               if (req_ff.cmd == dcrt_pkg::CMD_ENQUEUE) begin
                  if (end_tok.dup) begin
                     result_in.status = dcrt_pkg::STATUS_PENDING;
                  end else if (end_tok.have_free) begin
                     // reuse the lowest hole below the used length
                     result_in.status = dcrt_pkg::STATUS_QUEUED;
                     cmt_in.wr        = 1'b1;
                     cmt_idx_in       = end_free_idx;
                  end else if (len_ff < LEN_FULL) begin
                     // append at the end
                     result_in.status = dcrt_pkg::STATUS_QUEUED;
                     cmt_in.wr        = 1'b1;
                     cmt_idx_in       = len_ff[IDX_W-1:0];
                     len_in           = len_ff + LEN_ONE;
                  end else begin
                     result_in.status = dcrt_pkg::STATUS_FULL;
                  end
               end else begin
                  if (end_tok.have_valid) begin
                     result_in.status      = dcrt_pkg::STATUS_TAKEN;
                     result_in.taken_image = end_tok.last_image;
                     result_in.taken_block = end_tok.last_block;
                     cmt_in.clr            = 1'b1;
                     cmt_idx_in            = end_last_idx;
                     // only shrink when the last used slot goes away
                     if (taken_next == len_ff) begin
                        len_in = len_ff - LEN_ONE;
                     end
                  end else begin
                     result_in.status = dcrt_pkg::STATUS_NONE;
                  end
               end
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         len_ff       <= '0;
         cmt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= req_take;
         len_ff       <= len_in;
         cmt_ff       <= cmt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      cmt_idx_ff <= cmt_idx_in;
      result_ff  <= result_in;
      if (state_ff == S_DONE && rsp_free) begin
         rsp_data_ff <= result_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // used length never runs past the table
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_FULL)
      else $error("used length exceeds slot count");

   // a slot is never written and cleared by the same update
   a_cmt_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmt_ff.wr && cmt_ff.clr))
      else $error("write and clear issued together");

   // the token only leaves the chain while a scan is running
   a_tok_scan: assert property (@(posedge clock) disable iff (reset)
      end_tok.live |-> state_ff == S_SCAN)
      else $error("scan token outside of a scan");

   // updates to the cells happen only right after a scan finishes
   a_cmt_after_scan: assert property (@(posedge clock) disable iff (reset)
      (cmt_ff.wr || cmt_ff.clr) |-> state_ff == S_DONE)
      else $error("cell update outside of done state");

endmodule
